### sv/sbb_pkg.sv
// ----------------------------------------------------------------------------
// sbb_pkg: shared constants for the separable box blur
// Default geometry limits, configuration register indexes and stream codes.
// ----------------------------------------------------------------------------
package sbb_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;
    localparam int DEF_MAX_RADIUS = 8;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

    localparam int CFG_DATA_W = 11;

    localparam logic [3:0]  RADIUS_RESET = 4'd5;
    localparam logic [10:0] WIDTH_RESET  = 11'd1024;
    localparam logic [10:0] HEIGHT_RESET = 11'd1024;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

endpackage

### sv/separable_box_blur.sv
// ----------------------------------------------------------------------------
// separable_box_blur: two-pass box blur over a raster stream of RGBA pixels
// Horizontal pass over a small raw ring, vertical pass over a line store.
// ----------------------------------------------------------------------------
// Usage. Pixels of one frame enter on the s_ channel in raster order, one
// transfer per item; s_tuser is the opcode (pixel or drain tick). Blurred
// pixels leave on the m_ channel in raster order, output pixel p being
// produced by input item p + R*W + R; drain ticks supply the items after
// the last pixel, and m_tlast marks the final pixel of the frame.
// Registers are written over the cfg_ channel, which is always ready; the
// geometry is latched when the first pixel of a frame is accepted.
// Sequencing: items are worked one at a time by a sequencer, so s_tready is
// high only between items. Every item is accepted, decoded and advanced
// (the first pixel of a frame adds a latch step; an ignored drain tick is
// not advanced). Each horizontal result it completes, for a clipped window
// of c <= 2R+1 pixels, takes a setup, a read and an accumulate step per ring
// pixel, the divider and the write. An item with an output adds a setup, a
// row seek of up to R rows, the reads, the divider and the load.
// A finished pixel waits in the output register while the next item is
// accepted; if the receiver stalls, the block stops only when it has the
// next pixel ready. Reset (aresetn low, synchronous) restores the register
// defaults and starts a new frame; memory contents are not cleared.
// ----------------------------------------------------------------------------
module separable_box_blur
    import sbb_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int MAX_RADIUS = DEF_MAX_RADIUS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Input stream.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [31:0]           s_tdata,    // [31:0] pixel_in
    input  logic                  s_tuser,    // [0] opcode
    // Output stream.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [31:0]           m_tdata,    // [31:0] pixel_out
    output logic                  m_tlast,    // frame_last
    // Configuration writes.
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int RW    = $clog2(MAX_RADIUS + 2);
    localparam int XW    = ((WW > RW) ? WW : RW) + 1;
    localparam int YW    = ((HW > RW) ? HW : RW) + 1;
    localparam int RAWD  = 2 * MAX_RADIUS + 1;
    localparam int RAW_AW = $clog2(RAWD + 1);
    localparam int HD    = (2 * MAX_RADIUS + 1) * MAX_WIDTH + MAX_RADIUS;
    localparam int HAW   = $clog2(HD + 1) + 1;
    localparam int HIW   = $clog2(HD);
    localparam int NW    = $clog2(MAX_WIDTH * MAX_HEIGHT + MAX_RADIUS * MAX_WIDTH
                                  + MAX_RADIUS + 1);
    localparam int CNW   = $clog2(2 * MAX_RADIUS + 2);
    localparam int SW    = 8 + CNW;
    localparam int DCW   = $clog2(SW + 1);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_LATCH  = 4'd1;
    localparam logic [3:0] S_DECIDE = 4'd2;
    localparam logic [3:0] S_HINIT  = 4'd3;
    localparam logic [3:0] S_HRD    = 4'd4;
    localparam logic [3:0] S_HACC   = 4'd5;
    localparam logic [3:0] S_DIV    = 4'd6;
    localparam logic [3:0] S_HWR    = 4'd7;
    localparam logic [3:0] S_ADV    = 4'd8;
    localparam logic [3:0] S_VINIT  = 4'd9;
    localparam logic [3:0] S_VSEEK  = 4'd10;
    localparam logic [3:0] S_VRD    = 4'd11;
    localparam logic [3:0] S_VACC   = 4'd12;
    localparam logic [3:0] S_VOUT   = 4'd13;

    // Configuration registers.
    logic [3:0]  radius_reg;
    logic [10:0] width_reg;
    logic [10:0] height_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg <= RADIUS_RESET;
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_RADIUS: radius_reg <= cfg_data[3:0];
                REG_WIDTH:  width_reg  <= cfg_data;
                REG_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Geometry in use for the current frame.
    logic [RW-1:0]  gr_reg;
    logic [WW-1:0]  gw_reg;
    logic [HW-1:0]  gh_reg;
    logic [NW-1:0]  total_reg;
    logic [NW-1:0]  lag_reg;

    logic [3:0]     state_reg;
    logic           ret_v_reg;     // divider returns to the vertical path
    logic [NW-1:0]  n_reg;
    logic [31:0]    pix_reg;
    logic           op_reg;

    // Input position.
    logic [XW-1:0]     col_reg;
    logic [HAW-1:0]    in_base_reg;
    logic [RAW_AW-1:0] rptr_reg;      // ring slot of the current column

    // Horizontal job.
    logic [XW-1:0]     hx_reg;
    logic [XW-1:0]     hx_end_reg;
    logic [RAW_AW-1:0] rd_ptr_reg;

    // Output position.
    logic [XW-1:0]  ox_reg;
    logic [YW-1:0]  oy_reg;
    logic [HAW-1:0] out_base_reg;
    logic [NW-1:0]  outcnt_reg;
    logic [YW-1:0]  vrow_reg;
    logic [YW-1:0]  vlo_reg;
    logic [HAW-1:0] vaddr_reg;

    // Window accumulation and divider.
    logic [CNW-1:0] cnt_reg;
    logic [CNW-1:0] left_reg;
    logic [SW-1:0]  sum_reg [4];
    logic [SW-1:0]  quo_reg [4];
    logic [CNW:0]   rem_reg [4];
    logic [DCW-1:0] dstep_reg;

    // Memories.
    logic [31:0] raw_mem [RAWD];
    logic [31:0] raw_q;
    logic [31:0] hst_mem [HD];
    logic [31:0] hst_q;

    logic              raw_we;
    logic [RAW_AW-1:0] raw_addr;
    logic              hst_we;
    logic [HAW-1:0]    hst_waddr;
    logic [HAW-1:0]    hst_raddr;
    logic [31:0]       hst_wdata;

    always_ff @(posedge aclk) begin
        if (raw_we) begin
            raw_mem[raw_addr[RAW_AW-1:0]] <= pix_reg;
        end
        raw_q <= raw_mem[raw_addr[RAW_AW-1:0]];
    end

    // Line store addresses are always reduced below the depth.
    always_ff @(posedge aclk) begin
        if (hst_we) begin
            hst_mem[hst_waddr[HIW-1:0]] <= hst_wdata;
        end
        hst_q <= hst_mem[hst_raddr[HIW-1:0]];
    end

    // Helper values.
    logic [XW-1:0]  r_x;
    logic [YW-1:0]  r_y;
    logic [XW-1:0]  w_x;
    logic [YW-1:0]  h_y;
    logic [HAW-1:0] w_a;
    logic [HAW-1:0] hd_a;
    logic [XW-1:0]  h_lo, h_hi;
    logic [XW-1:0]  h_d;
    logic [YW-1:0]  v_lo, v_hi;
    logic [HAW-1:0] base_plus_x;
    logic [HAW-1:0] in_base_step;
    logic [HAW-1:0] out_base_step;
    logic           out_last;
    logic           col_last;
    logic           hjob;
    logic [XW-1:0]  hstart;

    assign r_x  = XW'(gr_reg);
    assign r_y  = YW'(gr_reg);
    assign w_x  = XW'(gw_reg);
    assign h_y  = YW'(gh_reg);
    assign w_a  = HAW'(gw_reg);
    assign hd_a = HAW'(HD);

    assign h_lo = (hx_reg >= r_x) ? hx_reg - r_x : '0;
    assign h_hi = (hx_reg + r_x <= w_x - 1'b1) ? hx_reg + r_x : w_x - 1'b1;
    assign h_d  = col_reg - h_lo;
    assign v_lo = (oy_reg >= r_y) ? oy_reg - r_y : '0;
    assign v_hi = (oy_reg + r_y <= h_y - 1'b1) ? oy_reg + r_y : h_y - 1'b1;

    assign base_plus_x   = (out_base_reg + HAW'(ox_reg) >= hd_a)
                         ? out_base_reg + HAW'(ox_reg) - hd_a
                         : out_base_reg + HAW'(ox_reg);
    assign in_base_step  = (in_base_reg + w_a >= hd_a) ? in_base_reg + w_a - hd_a
                                                       : in_base_reg + w_a;
    assign out_base_step = (out_base_reg + w_a >= hd_a) ? out_base_reg + w_a - hd_a
                                                        : out_base_reg + w_a;
    assign out_last  = (outcnt_reg == total_reg - 1'b1);
    assign col_last  = (col_reg == w_x - 1'b1);
    assign hjob      = (col_reg >= r_x) || col_last;
    // Columns whose right edge is clipped are finished at the row end.
    assign hstart    = (col_reg >= r_x) ? col_reg - r_x
                     : ((w_x > r_x) ? w_x - r_x : '0);

    // Memory port control.
    always_comb begin
        raw_we    = 1'b0;
        raw_addr  = rd_ptr_reg;
        hst_we    = 1'b0;
        hst_raddr = vaddr_reg;
        hst_waddr = (in_base_reg + HAW'(hx_reg) >= hd_a)
                  ? in_base_reg + HAW'(hx_reg) - hd_a
                  : in_base_reg + HAW'(hx_reg);
        hst_wdata = {quo_reg[3][7:0], quo_reg[2][7:0], quo_reg[1][7:0], quo_reg[0][7:0]};
        if (state_reg == S_DECIDE) begin
            raw_addr = rptr_reg;
            raw_we   = (n_reg < total_reg) && (op_reg == OP_PIXEL);
        end
        if (state_reg == S_HWR) begin
            hst_we = 1'b1;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            n_reg        <= '0;
            gr_reg       <= RW'(5 > MAX_RADIUS ? MAX_RADIUS : 5);
            gw_reg       <= WW'(1024 > MAX_WIDTH ? MAX_WIDTH : 1024);
            gh_reg       <= HW'(1024 > MAX_HEIGHT ? MAX_HEIGHT : 1024);
            total_reg    <= '0;
            lag_reg      <= '0;
            col_reg      <= '0;
            in_base_reg  <= '0;
            rptr_reg     <= '0;
            ox_reg       <= '0;
            oy_reg       <= '0;
            out_base_reg <= '0;
            outcnt_reg   <= '0;
            m_tvalid     <= 1'b0;
            ret_v_reg    <= 1'b0;
        end else begin
            // The output state loads or holds the output register itself.
            if (m_tvalid && m_tready && (state_reg != S_VOUT)) begin
                m_tvalid <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        pix_reg <= s_tdata;
                        op_reg  <= s_tuser;
                        if (n_reg == '0) begin
                            if (s_tuser == OP_PIXEL) begin
                                gr_reg <= (32'(radius_reg) > MAX_RADIUS)
                                        ? RW'(MAX_RADIUS) : RW'(radius_reg);
                                gw_reg <= (width_reg == '0) ? WW'(1)
                                        : ((32'(width_reg) > MAX_WIDTH)
                                           ? WW'(MAX_WIDTH) : WW'(width_reg));
                                gh_reg <= (height_reg == '0) ? HW'(1)
                                        : ((32'(height_reg) > MAX_HEIGHT)
                                           ? HW'(MAX_HEIGHT) : HW'(height_reg));
                                state_reg <= S_LATCH;
                            end
                        end else begin
                            state_reg <= S_DECIDE;
                        end
                    end
                end
                S_LATCH: begin
                    total_reg <= NW'(gw_reg * gh_reg);
                    lag_reg   <= NW'(gr_reg * gw_reg) + NW'(gr_reg);
                    state_reg <= S_DECIDE;
                end
                S_DECIDE: begin
                    if (n_reg < total_reg) begin
                        if (op_reg != OP_PIXEL) begin
                            state_reg <= S_IDLE;
                        end else if (hjob) begin
                            hx_reg     <= hstart;
                            hx_end_reg <= col_last ? w_x - 1'b1 : col_reg - r_x;
                            state_reg  <= S_HINIT;
                        end else begin
                            state_reg <= S_ADV;
                        end
                    end else begin
                        state_reg <= S_ADV;
                    end
                end
                S_HINIT: begin
                    cnt_reg    <= CNW'(h_hi - h_lo + 1'b1);
                    left_reg   <= CNW'(h_hi - h_lo + 1'b1);
                    rd_ptr_reg <= (rptr_reg >= RAW_AW'(h_d))
                                ? rptr_reg - RAW_AW'(h_d)
                                : rptr_reg + RAW_AW'(RAWD) - RAW_AW'(h_d);
                    for (int i = 0; i < 4; i++) sum_reg[i] <= '0;
                    ret_v_reg  <= 1'b0;
                    state_reg  <= S_HRD;
                end
                S_HRD: begin
                    state_reg <= S_HACC;
                end
                S_HACC: begin
                    for (int i = 0; i < 4; i++) begin
                        sum_reg[i] <= sum_reg[i] + SW'(raw_q[8*i +: 8]);
                    end
                    rd_ptr_reg <= (rd_ptr_reg == RAW_AW'(RAWD - 1)) ? '0
                                                                    : rd_ptr_reg + 1'b1;
                    left_reg <= left_reg - 1'b1;
                    if (left_reg == CNW'(1)) begin
                        for (int i = 0; i < 4; i++) rem_reg[i] <= '0;
                        dstep_reg <= '0;
                        state_reg <= S_DIV;
                    end else begin
                        state_reg <= S_HRD;
                    end
                end
                S_DIV: begin
                    // One restoring step per cycle, four channels side by side.
                    for (int i = 0; i < 4; i++) begin
                        if ({rem_reg[i][CNW-1:0], sum_reg[i][SW-1]} >= {1'b0, cnt_reg}) begin
                            rem_reg[i] <= {rem_reg[i][CNW-1:0], sum_reg[i][SW-1]}
                                        - {1'b0, cnt_reg};
                            quo_reg[i] <= {quo_reg[i][SW-2:0], 1'b1};
                        end else begin
                            rem_reg[i] <= {rem_reg[i][CNW-1:0], sum_reg[i][SW-1]};
                            quo_reg[i] <= {quo_reg[i][SW-2:0], 1'b0};
                        end
                        sum_reg[i] <= {sum_reg[i][SW-2:0], 1'b0};
                    end
                    dstep_reg <= dstep_reg + 1'b1;
                    if (dstep_reg == DCW'(SW - 1)) begin
                        state_reg <= ret_v_reg ? S_VOUT : S_HWR;
                    end
                end
                S_HWR: begin
                    if (hx_reg == hx_end_reg) begin
                        state_reg <= S_ADV;
                    end else begin
                        hx_reg    <= hx_reg + 1'b1;
                        state_reg <= S_HINIT;
                    end
                end
                S_ADV: begin
                    if (n_reg < total_reg) begin
                        if (col_last) begin
                            col_reg     <= '0;
                            in_base_reg <= in_base_step;
                            rptr_reg    <= '0;
                        end else begin
                            col_reg  <= col_reg + 1'b1;
                            rptr_reg <= (rptr_reg == RAW_AW'(RAWD - 1)) ? '0
                                                                       : rptr_reg + 1'b1;
                        end
                    end
                    if (n_reg >= lag_reg) begin
                        state_reg <= S_VINIT;
                    end else begin
                        n_reg     <= n_reg + 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                S_VINIT: begin
                    cnt_reg   <= CNW'(v_hi - v_lo + 1'b1);
                    left_reg  <= CNW'(v_hi - v_lo + 1'b1);
                    vlo_reg   <= v_lo;
                    vrow_reg  <= oy_reg;
                    vaddr_reg <= base_plus_x;
                    for (int i = 0; i < 4; i++) sum_reg[i] <= '0;
                    ret_v_reg <= 1'b1;
                    state_reg <= S_VSEEK;
                end
                S_VSEEK: begin
                    // Walk back from the output row to the top of the window.
                    if (vrow_reg > vlo_reg) begin
                        vrow_reg  <= vrow_reg - 1'b1;
                        vaddr_reg <= (vaddr_reg >= w_a) ? vaddr_reg - w_a
                                                        : vaddr_reg + hd_a - w_a;
                    end else begin
                        state_reg <= S_VRD;
                    end
                end
                S_VRD: begin
                    vaddr_reg <= (vaddr_reg + w_a >= hd_a) ? vaddr_reg + w_a - hd_a
                                                           : vaddr_reg + w_a;
                    state_reg <= S_VACC;
                end
                S_VACC: begin
                    for (int i = 0; i < 4; i++) begin
                        sum_reg[i] <= sum_reg[i] + SW'(hst_q[8*i +: 8]);
                    end
                    left_reg <= left_reg - 1'b1;
                    if (left_reg == CNW'(1)) begin
                        for (int i = 0; i < 4; i++) rem_reg[i] <= '0;
                        dstep_reg <= '0;
                        state_reg <= S_DIV;
                    end else begin
                        state_reg <= S_VRD;
                    end
                end
                S_VOUT: begin
                    if (!m_tvalid || m_tready) begin
                        m_tvalid  <= 1'b1;
                        m_tdata   <= hst_wdata;
                        m_tlast   <= out_last;
                        state_reg <= S_IDLE;
                        if (out_last) begin
                            n_reg        <= '0;
                            outcnt_reg   <= '0;
                            ox_reg       <= '0;
                            oy_reg       <= '0;
                            out_base_reg <= '0;
                            col_reg      <= '0;
                            in_base_reg  <= '0;
                            rptr_reg     <= '0;
                        end else begin
                            n_reg      <= n_reg + 1'b1;
                            outcnt_reg <= outcnt_reg + 1'b1;
                            if (ox_reg == w_x - 1'b1) begin
                                ox_reg       <= '0;
                                oy_reg       <= oy_reg + 1'b1;
                                out_base_reg <= out_base_step;
                            end else begin
                                ox_reg <= ox_reg + 1'b1;
                            end
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule
